### src/arq_retransmit_tracker_defines.svh
// ----------------------------------------------------------------------------
// ARQ retransmit tracker assertion macros
// Shorthand for the concurrent checks on clk, with rst as the disable term.
// ----------------------------------------------------------------------------
`ifndef ARQ_RETRANSMIT_TRACKER_DEFINES_SVH
`define ARQ_RETRANSMIT_TRACKER_DEFINES_SVH

// same-cycle implication
`define ARQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ARQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/arq_pkg.sv
// ----------------------------------------------------------------------------
// ARQ tracker package
// Field widths, operation and status codes, and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package arq_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int TICK_WIDTH_DEF   = 16;

  localparam int MODE_W     = 2;
  localparam int ID_W       = 6;
  localparam int STATUS_W   = 2;
  localparam int TIMEOUT_W  = 15;
  localparam int SEGCNT_W   = 7;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 15;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(100);

  localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SEG_COUNT = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_SEND  = 2'd0,
    MODE_ACK   = 2'd1,
    MODE_CHECK = 2'd2,
    MODE_TICK  = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE        = 2'd0,
    STATUS_ACKED       = 2'd1,
    STATUS_OUTSTANDING = 2'd2,
    STATUS_NONE        = 2'd3
  } status_e;

  // per-segment flags carried along the cell row
  typedef struct packed {
    logic valid;
    logic acked;
  } seg_flags_t;

  typedef struct packed {
    logic            all_acked;
    logic [ID_W-1:0] resend_id;
    logic            resend_valid;
    status_e         status;
  } arq_result_t;

endpackage

`default_nettype wire

### src/arq_cell.sv
// ----------------------------------------------------------------------------
// ARQ tracker cell
// Holds one segment entry and takes its neighbor's entry on each shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arq_cell
  import arq_pkg::*;
#(
  parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  shift,
  input  wire seg_flags_t            in_flags,
  input  wire logic [TICK_WIDTH-1:0] in_tick,
  output seg_flags_t                 flags,
  output logic      [TICK_WIDTH-1:0] tick
);

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (shift) begin
      flags <= in_flags;
    end
  end

  // send tick is only read behind a valid flag
  always_ff @(posedge clk) begin
    if (shift) begin
      tick <= in_tick;
    end
  end

endmodule

`default_nettype wire

### src/arq_head.sv
// ----------------------------------------------------------------------------
// ARQ tracker head unit
// Updates the entry passing the head of the row and builds the item result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arq_head
  import arq_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int TICK_WIDTH   = TICK_WIDTH_DEF,
  parameter int IDX_W        = $clog2(MAX_SEGMENTS)
) (
  input  wire logic                  clk,
  input  wire logic                  start,
  input  wire mode_e                 start_mode,
  input  wire logic [ID_W-1:0]       start_id,
  input  wire logic                  step,
  input  wire logic [IDX_W-1:0]      idx,
  input  wire logic [TICK_WIDTH-1:0] cur_tick,
  input  wire logic [TIMEOUT_W-1:0]  timeout,
  input  wire logic [SEGCNT_W-1:0]   seg_count,
  input  wire seg_flags_t            head_flags,
  input  wire logic [TICK_WIDTH-1:0] head_tick,
  output seg_flags_t                 new_flags,
  output logic      [TICK_WIDTH-1:0] new_tick,
  output arq_result_t                result
);

  localparam int SEL_W = (IDX_W > ID_W) ? IDX_W : ID_W;
  localparam int CNT_W = (IDX_W > SEGCNT_W) ? IDX_W : SEGCNT_W;
  localparam int AGE_W = (TICK_WIDTH > TIMEOUT_W) ? TICK_WIDTH : TIMEOUT_W;

  mode_e                 op_mode;
  logic [ID_W-1:0]       op_id;
  status_e               status;
  logic                  found;
  logic [TICK_WIDTH-1:0] best_age;
  logic [ID_W-1:0]       best_id;
  logic                  all_acked;

  logic                  sel;
  logic                  in_count;
  logic [TICK_WIDTH-1:0] age;
  logic                  expired;
  logic                  take;

  assign sel      = (SEL_W'(idx) == SEL_W'(op_id));
  assign in_count = (CNT_W'(idx) < CNT_W'(seg_count));
  assign age      = cur_tick - head_tick;
  assign expired  = (op_mode == MODE_CHECK) && head_flags.valid &&
                    (AGE_W'(age) > AGE_W'(timeout));
  // scan runs upward, so an equal age lets the higher id win
  assign take     = expired && (!found || (age <= best_age));

  always_comb begin
    new_flags = head_flags;
    new_tick  = head_tick;
    unique case (op_mode)
      MODE_SEND: begin
        if (sel && !head_flags.acked && !head_flags.valid) begin
          new_flags.valid = 1'b1;
          new_tick        = cur_tick;
        end
      end
      MODE_ACK: begin
        if (sel) begin
          new_flags.valid = 1'b0;
          new_flags.acked = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_mode   <= start_mode;
      op_id     <= start_id;
      status    <= STATUS_DONE;
      found     <= 1'b0;
      best_age  <= '0;
      best_id   <= '0;
      all_acked <= 1'b1;
    end else if (step) begin
      if (sel && (op_mode == MODE_SEND)) begin
        if (head_flags.acked) begin
          status <= STATUS_ACKED;
        end else if (head_flags.valid) begin
          status <= STATUS_OUTSTANDING;
        end
      end
      if (take) begin
        found    <= 1'b1;
        best_age <= age;
        best_id  <= ID_W'(idx);
      end
      all_acked <= all_acked & (new_flags.acked | !in_count);
    end
  end

  always_comb begin
    result.status       = (op_mode == MODE_CHECK) ? (found ? STATUS_DONE : STATUS_NONE)
                                                  : status;
    result.resend_valid = found;
    result.resend_id    = best_id;
    result.all_acked    = all_acked;
  end

endmodule

`default_nettype wire

### src/arq_retransmit_tracker.sv
// Each item rotates the whole cell row once past the single head unit, which holds the
//   age comparisons; the finished result is then loaded into the output register once
//   that register is free. The input stays closed until then, so a new item is taken
//   only after the previous one has left the ring.
// The next item is taken while the previous result waits in the output register.
// Reset clears the outstanding and acknowledged flags, the tick counter and the
//   registers (timeout 100, segment count 0); stored send ticks are not cleared.
// ----------------------------------------------------------------------------
// ARQ retransmit tracker
// Selective-repeat sender table of outstanding segments held in a ring of cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arq_retransmit_tracker
  import arq_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int TICK_WIDTH   = TICK_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // segment_id[5:0], zero pad[7:6]
  input  wire logic [MODE_W-1:0]     s_tuser,   // mode[1:0]
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // status[1:0], resend_valid[2], resend_id[8:3], all_acked[9], zero pad[15:10]
  output logic      [OUT_DATA_W-1:0] m_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int                IDX_W = $clog2(MAX_SEGMENTS);
  localparam logic [IDX_W-1:0]  LAST  = IDX_W'(MAX_SEGMENTS - 1);
  localparam int                PAD_W = OUT_DATA_W - ($bits(arq_result_t));

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HOLD
  } state_t;

  state_t                state;
  logic [IDX_W-1:0]      idx;
  logic [TICK_WIDTH-1:0] current_tick;
  logic [TIMEOUT_W-1:0]  timeout_ticks;
  logic [SEGCNT_W-1:0]   segment_count;

  logic                  start;
  logic                  step;
  logic                  out_free;
  logic                  emit;

  seg_flags_t            cell_flags [MAX_SEGMENTS];
  logic [TICK_WIDTH-1:0] cell_tick  [MAX_SEGMENTS];
  seg_flags_t            new_flags;
  logic [TICK_WIDTH-1:0] new_tick;
  arq_result_t           result;

  assign s_tready = (state == S_IDLE);
  assign start    = s_tvalid && s_tready;
  assign step     = (state == S_SCAN);
  assign out_free = !m_tvalid || m_tready;
  // the head registers have taken the last entry once the scan has ended
  assign emit     = (state == S_HOLD) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      segment_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_TIMEOUT:   timeout_ticks <= cfg_wdata[TIMEOUT_W-1:0];
        CFG_SEG_COUNT: segment_count <= cfg_wdata[SEGCNT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      idx          <= '0;
      current_tick <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {PAD_W'(0), result};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_SCAN;
            idx   <= '0;
            if (mode_e'(s_tuser) == MODE_TICK) begin
              current_tick <= current_tick + TICK_WIDTH'(1);
            end
          end
        end
        S_SCAN: begin
          if (idx == LAST) begin
            idx   <= '0;
            state <= S_HOLD;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_HOLD: begin
          if (emit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ring: each cell takes its upper neighbor, the top cell takes the head's update
  for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
    if (k == MAX_SEGMENTS - 1) begin : g_top
      arq_cell #(
        .TICK_WIDTH (TICK_WIDTH)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (step),
        .in_flags (new_flags),
        .in_tick  (new_tick),
        .flags    (cell_flags[k]),
        .tick     (cell_tick[k])
      );
    end else begin : g_mid
      arq_cell #(
        .TICK_WIDTH (TICK_WIDTH)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (step),
        .in_flags (cell_flags[k+1]),
        .in_tick  (cell_tick[k+1]),
        .flags    (cell_flags[k]),
        .tick     (cell_tick[k])
      );
    end
  end

  arq_head #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .TICK_WIDTH   (TICK_WIDTH),
    .IDX_W        (IDX_W)
  ) u_head (
    .clk        (clk),
    .start      (start),
    .start_mode (mode_e'(s_tuser)),
    .start_id   (s_tdata[ID_W-1:0]),
    .step       (step),
    .idx        (idx),
    .cur_tick   (current_tick),
    .timeout    (timeout_ticks),
    .seg_count  (segment_count),
    .head_flags (cell_flags[0]),
    .head_tick  (cell_tick[0]),
    .new_flags  (new_flags),
    .new_tick   (new_tick),
    .result     (result)
  );

endmodule

`default_nettype wire

### src/arq_retransmit_tracker_checker.sv
// ----------------------------------------------------------------------------
// ARQ tracker port checker
// Watches the top-level ports for result encoding and handshake slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "arq_retransmit_tracker_defines.svh"

module arq_checker
  import arq_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tvalid,
  input wire logic                  s_tready,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata
);

  // stalled result holds
  `ARQ_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // an accepted item keeps the input closed while the ring turns
  `ARQ_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input open right after accept")

  // a found segment always reports status done
  `ARQ_ASSERT_IMP(a_resend_status, m_tvalid && m_tdata[2], m_tdata[1:0] == STATUS_DONE, "resend with non-done status")

  // no resend id without a resend
  `ARQ_ASSERT_IMP(a_resend_id_zero, m_tvalid && !m_tdata[2], m_tdata[8:3] == '0, "resend id set without resend")

endmodule

bind arq_retransmit_tracker arq_checker u_arq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
